// ===== design/zefs_pkg.sv =====
// zefs_pkg: shared constants and types for the zip extra field scrubber.
// Record signatures, header lengths, status codes and record kinds.
// No dependencies.
`timescale 1ns / 1ps

package zefs_pkg;

  // Little-endian record signatures as assembled from four archive bytes
  localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
  localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
  localparam logic [31:0] SIG_END     = 32'h06054b50;
  localparam logic [31:0] SIG_SIGREC  = 32'h05054b50;

  localparam int          DESC_FLAG_BIT   = 3;
  localparam logic [5:0]  LOCAL_HDR_LEN   = 6'd30;
  localparam logic [5:0]  CENTRAL_HDR_LEN = 6'd46;
  localparam logic [5:0]  SIGREC_HDR_LEN  = 6'd6;
  localparam logic [5:0]  SIG_LEN         = 6'd4;
  localparam logic [7:0]  DESC_SKIP_RESET = 8'd24;

  // Header offset counter holds the record kind once a local or central header is done
  localparam logic [5:0]  KIND_LOCAL   = 6'd1;
  localparam logic [5:0]  KIND_CENTRAL = 6'd2;

  // Register map
  localparam logic        REG_DESC_SKIP = 1'b0;

  typedef enum logic [1:0] {
    ST_SCAN   = 2'd0,
    ST_FOUND  = 2'd1,
    ST_BADSIG = 2'd2,
    ST_NOEND  = 2'd3
  } status_t;

endpackage

// ===== design/zip_extra_field_scrubber.sv =====
// zip_extra_field_scrubber: walks a zip archive byte stream and zeroes extra fields
// and central comments. Depends on zefs_pkg for signatures, lengths and status codes.
// Timing: one byte accepted per cycle when the output register is empty or drains;
// the result transaction is registered; the record walk is one state update per byte.
// Reset (rst_n low, synchronous): walk returns to signature collection, status to
// scanning, descriptor_skip to 24, output register empty.
`timescale 1ns / 1ps

module zip_extra_field_scrubber (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_end_of_file,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import zefs_pkg::*;

  // Walk phases: signature collect, the three header kinds, the name,
  // the zeroed span (extra field, plus comment for central headers),
  // the passed body (file data or signature record payload) and done.
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LHDR = 3'd1,
    PH_CHDR = 3'd2,
    PH_SHDR = 3'd3,
    PH_NAME = 3'd4,
    PH_ZERO = 3'd5,
    PH_BODY = 3'd6,
    PH_DONE = 3'd7
  } phase_t;

  // ---------------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------------
  phase_t      phase_r,    phase_nxt;
  logic [5:0]  hidx_r,     hidx_nxt;     // header offset, or record kind
  logic [31:0] sig_r,      sig_nxt;
  logic        dflag_r,    dflag_nxt;
  logic [31:0] comp_len_r, comp_len_nxt;
  logic [15:0] name_len_r, name_len_nxt;
  logic [15:0] extra_len_r, extra_len_nxt;
  logic [15:0] cmt_len_r,  cmt_len_nxt;  // also the signature record length
  logic [32:0] rem_r,      rem_nxt;
  status_t     status_r,   status_nxt;

  logic [7:0]  desc_skip_r;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  status_t     out_status_r;
  logic        out_eof_r;

  logic        in_fire;
  logic        cfg_wr;
  logic [7:0]  ob;

  // Take a new transaction whenever the output register is empty or drains
  // in this same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Configuration port: a single register, always ready
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DESC_SKIP);
  assign prdata = (paddr[2] == REG_DESC_SKIP) ? {24'd0, desc_skip_r} : 32'd0;

  // ---------------------------------------------------------------------------
  // Per-byte walk update
  // ---------------------------------------------------------------------------
  always_comb begin
    logic        do_adv;
    logic        go_zero;
    logic        zero_exit;
    logic [16:0] zero_len;
    logic [32:0] body_len;
    logic [32:0] rem_dec;

    phase_nxt     = phase_r;
    hidx_nxt      = hidx_r;
    sig_nxt       = sig_r;
    dflag_nxt     = dflag_r;
    comp_len_nxt  = comp_len_r;
    name_len_nxt  = name_len_r;
    extra_len_nxt = extra_len_r;
    cmt_len_nxt   = cmt_len_r;
    rem_nxt       = rem_r;
    status_nxt    = status_r;
    ob            = in_data_byte;
    do_adv        = 1'b0;
    go_zero       = 1'b0;
    zero_exit     = 1'b0;
    zero_len      = 17'd0;
    body_len      = 33'd0;
    rem_dec       = (rem_r != 33'd0) ? rem_r - 33'd1 : rem_r;

    if (in_fire) begin
      case (phase_r)
        PH_SIG: begin
          // Shift in little-endian; decode on the fourth byte
          sig_nxt  = {in_data_byte, sig_r[31:8]};
          hidx_nxt = hidx_r + 6'd1;
          if (hidx_nxt == SIG_LEN) begin
            dflag_nxt     = 1'b0;
            comp_len_nxt  = 32'd0;
            name_len_nxt  = 16'd0;
            extra_len_nxt = 16'd0;
            cmt_len_nxt   = 16'd0;
            rem_nxt       = 33'd0;
            if (sig_nxt == SIG_LOCAL) begin
              phase_nxt = PH_LHDR;
            end else if (sig_nxt == SIG_CENTRAL) begin
              phase_nxt = PH_CHDR;
            end else if (sig_nxt == SIG_SIGREC) begin
              phase_nxt = PH_SHDR;
            end else if (sig_nxt == SIG_END) begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_FOUND;
            end else begin
              // Unknown record: latch the error and stop walking
              phase_nxt  = PH_DONE;
              status_nxt = ST_BADSIG;
            end
          end
        end
        PH_LHDR: begin
          case (hidx_r)
            6'd6:  dflag_nxt = in_data_byte[DESC_FLAG_BIT];
            6'd18: comp_len_nxt[7:0]    = comp_len_r[7:0]    | in_data_byte;
            6'd19: comp_len_nxt[15:8]   = comp_len_r[15:8]   | in_data_byte;
            6'd20: comp_len_nxt[23:16]  = comp_len_r[23:16]  | in_data_byte;
            6'd21: comp_len_nxt[31:24]  = comp_len_r[31:24]  | in_data_byte;
            6'd26: name_len_nxt[7:0]    = name_len_r[7:0]    | in_data_byte;
            6'd27: name_len_nxt[15:8]   = name_len_r[15:8]   | in_data_byte;
            6'd28: extra_len_nxt[7:0]   = extra_len_r[7:0]   | in_data_byte;
            6'd29: extra_len_nxt[15:8]  = extra_len_r[15:8]  | in_data_byte;
            default: ;
          endcase
          hidx_nxt = hidx_r + 6'd1;
          if (hidx_r >= LOCAL_HDR_LEN - 6'd1) begin
            hidx_nxt = KIND_LOCAL;
            do_adv   = 1'b1;
          end
        end
        PH_CHDR: begin
          case (hidx_r)
            6'd28: name_len_nxt[7:0]    = name_len_r[7:0]    | in_data_byte;
            6'd29: name_len_nxt[15:8]   = name_len_r[15:8]   | in_data_byte;
            6'd30: extra_len_nxt[7:0]   = extra_len_r[7:0]   | in_data_byte;
            6'd31: extra_len_nxt[15:8]  = extra_len_r[15:8]  | in_data_byte;
            6'd32: cmt_len_nxt[7:0]     = cmt_len_r[7:0]     | in_data_byte;
            6'd33: cmt_len_nxt[15:8]    = cmt_len_r[15:8]    | in_data_byte;
            default: ;
          endcase
          hidx_nxt = hidx_r + 6'd1;
          if (hidx_r >= CENTRAL_HDR_LEN - 6'd1) begin
            hidx_nxt = KIND_CENTRAL;
            do_adv   = 1'b1;
          end
        end
        PH_SHDR: begin
          case (hidx_r)
            6'd4:  cmt_len_nxt[7:0]  = cmt_len_r[7:0]  | in_data_byte;
            6'd5:  cmt_len_nxt[15:8] = cmt_len_r[15:8] | in_data_byte;
            default: ;
          endcase
          hidx_nxt = hidx_r + 6'd1;
          if (hidx_r >= SIGREC_HDR_LEN - 6'd1) begin
            do_adv = 1'b1;
          end
        end
        PH_NAME, PH_ZERO, PH_BODY: begin
          if (phase_r == PH_ZERO) begin
            ob = 8'd0;
          end
          rem_nxt = rem_dec;
          if (rem_dec == 33'd0) begin
            do_adv = 1'b1;
          end
        end
        default: ;
      endcase

      // Move to the next segment, skipping empty ones in the same cycle
      if (do_adv) begin
        case (phase_r)
          PH_LHDR, PH_CHDR: begin
            if (name_len_nxt != 16'd0) begin
              phase_nxt = PH_NAME;
              rem_nxt   = {17'd0, name_len_nxt};
            end else begin
              go_zero = 1'b1;
            end
          end
          PH_NAME: go_zero = 1'b1;
          PH_ZERO: zero_exit = 1'b1;
          PH_SHDR: begin
            rem_nxt   = {17'd0, cmt_len_nxt};
            phase_nxt = (cmt_len_nxt != 16'd0) ? PH_BODY : PH_SIG;
          end
          PH_BODY: phase_nxt = PH_SIG;
          default: ;
        endcase

        if (go_zero) begin
          zero_len = {1'b0, extra_len_nxt} +
                     ((hidx_nxt == KIND_CENTRAL) ? {1'b0, cmt_len_nxt} : 17'd0);
          rem_nxt  = {16'd0, zero_len};
          if (zero_len != 17'd0) begin
            phase_nxt = PH_ZERO;
          end else begin
            zero_exit = 1'b1;
          end
        end

        if (zero_exit) begin
          if (hidx_nxt == KIND_LOCAL) begin
            body_len  = {1'b0, comp_len_nxt} +
                        (dflag_nxt ? {25'd0, desc_skip_r} : 33'd0);
            rem_nxt   = body_len;
            phase_nxt = (body_len != 33'd0) ? PH_BODY : PH_SIG;
          end else begin
            phase_nxt = PH_SIG;
          end
        end

        if (phase_nxt == PH_SIG) begin
          hidx_nxt = 6'd0;
          sig_nxt  = 32'd0;
        end
      end

      // Archive ended mid-walk: flag the missing end record and stop
      if (in_is_last && (status_nxt == ST_SCAN)) begin
        status_nxt = ST_NOEND;
        phase_nxt  = PH_DONE;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // State, configuration and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      hidx_r      <= 6'd0;
      sig_r       <= 32'd0;
      dflag_r     <= 1'b0;
      comp_len_r  <= 32'd0;
      name_len_r  <= 16'd0;
      extra_len_r <= 16'd0;
      cmt_len_r   <= 16'd0;
      rem_r       <= 33'd0;
      status_r    <= ST_SCAN;
      desc_skip_r <= DESC_SKIP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hidx_r      <= hidx_nxt;
      sig_r       <= sig_nxt;
      dflag_r     <= dflag_nxt;
      comp_len_r  <= comp_len_nxt;
      name_len_r  <= name_len_nxt;
      extra_len_r <= extra_len_nxt;
      cmt_len_r   <= cmt_len_nxt;
      rem_r       <= rem_nxt;
      status_r    <= status_nxt;
      if (cfg_wr) begin
        desc_skip_r <= pwdata[7:0];
      end
      // Load a fresh result, or drop the one just taken
      if (in_fire) begin
        out_valid_r  <= 1'b1;
        out_byte_r   <= ob;
        out_status_r <= status_nxt;
        out_eof_r    <= in_is_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_status      = out_status_r;
  assign out_end_of_file = out_eof_r;

`ifndef SYNTH
  // A final status never changes until reset
  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != ST_SCAN) |=> (status_r == $past(status_r)))
    else $error("final status changed");

  // Any final status means the walk has stopped
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != ST_SCAN) |-> (phase_r == PH_DONE))
    else $error("final status while still walking");

  // Segment phases always have bytes left to count
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NAME || phase_r == PH_ZERO || phase_r == PH_BODY) |->
    (rem_r != 33'd0))
    else $error("segment phase with empty count");

  // A byte taken inside the zeroed span leaves as zero
  a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_ZERO) |=> (out_valid_r && out_byte_r == 8'd0))
    else $error("extra field byte not cleared");
`endif

endmodule
